// File: rtl/batch_insertion_sorter_unit_defines.svh
// Assertion macros shared by the batch insertion sorter checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BATCH_INSERTION_SORTER_UNIT_DEFINES_SVH
`define BATCH_INSERTION_SORTER_UNIT_DEFINES_SVH

// Property checked on every rising edge outside of reset.
`define BIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Property checked on every rising edge, reset included.
`define BIS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/bis_pkg.sv
// Shared types and constants for the batch insertion sorter.
// No dependencies; imported by the controller, datapath and top level.
package bis_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int VALUE_W   = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;     // place the input word into the sorted row
        logic set_drop;   // row is full, flag that a word was dropped
        logic shift;      // move every slot but the last down by one toward slot 0
        logic finish;     // final word of the batch leaves, clear the drop flag
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic one_left;
        logic dropped;
    } t_dp_status;

endpackage

// File: rtl/bis_ctrl.sv
// Controller of the batch insertion sorter: collect and emit phases.
// Depends on bis_pkg for the command and status structs.
module bis_ctrl
    import bis_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_last,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_emit
);

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_EMIT    = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign accept = i_start && (r_state == ST_COLLECT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_COLLECT: begin
                o_cmd.insert   = accept && !i_status.full;
                o_cmd.set_drop = accept && i_status.full;
                if (accept && i_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.shift  = 1'b1;
                o_cmd.finish = i_status.one_left;
                if (i_status.one_left) begin
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state == ST_EMIT);
    assign o_emit = (r_state == ST_EMIT);

endmodule

// File: rtl/bis_datapath.sv
// Datapath of the batch insertion sorter: a row of compare-and-shift cells,
// the fill count and the drop flag. Depends on bis_pkg.
module bis_datapath
    import bis_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic signed [VALUE_W-1:0] i_value,
    output t_dp_status                o_status,
    output logic signed [VALUE_W-1:0] o_head
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [VALUE_W-1:0] r_slot [DEPTH];
    logic [CNT_W-1:0]          r_count;
    logic                      r_drop;
    logic [DEPTH-1:0]          gt;
    logic [DEPTH-1:0]          take_prev;
    logic [DEPTH-1:0]          take_new;

    // Each occupied cell compares its word with the new one. Because the row
    // is sorted, the cells holding larger words form a run at the top end.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

        assign gt[i] = (IDX < r_count) && (r_slot[i] > i_value);

        if (i == 0) begin : g_first
            assign take_prev[i] = 1'b0;
        end else begin : g_rest
            assign take_prev[i] = gt[i-1];
        end

        // The new word lands in the lowest larger cell, or just past the end.
        assign take_new[i] = (gt[i] || (IDX == r_count)) && !take_prev[i];
    end

    // The end cells clamp their neighbor index; the clamped arm is never taken.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_cmd.insert) begin
                if (take_prev[i]) begin
                    r_slot[i] <= r_slot[(i > 0) ? i - 1 : 0];
                end else if (take_new[i]) begin
                    r_slot[i] <= i_value;
                end
            end else if (i_cmd.shift && (i < DEPTH - 1)) begin
                r_slot[i] <= r_slot[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            if (i_cmd.insert) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.shift) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.set_drop) begin
                r_drop <= 1'b1;
            end else if (i_cmd.finish) begin
                r_drop <= 1'b0;
            end
        end
    end

    assign o_status.full     = (r_count == CNT_W'(DEPTH));
    assign o_status.one_left = (r_count == CNT_W'(1));
    assign o_status.dropped  = r_drop;
    assign o_head            = r_slot[0];

endmodule

// File: rtl/batch_insertion_sorter_unit.sv
// Top level of the batch insertion sorter: controller plus cell datapath.
// Depends on bis_pkg, bis_ctrl and bis_datapath.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+------------------------------------
//  input   | in        | start && !busy      | i_value, i_last
//  result  | out       | o_res_valid strobe  | o_value_res, o_last_res, o_overflow
//
// An input word is inserted in the cycle it is accepted, so words of a batch
// can arrive back to back while busy is low.
// After the word marked last, the held words leave one per cycle from slot 0
// as the cell row shifts down; busy is high while they leave. Reset is
// synchronous, active low, and empties the row.
// The receiver cannot stall: each result shows for exactly one cycle.
module batch_insertion_sorter_unit
    import bis_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_last,
    output logic                      o_res_valid,
    output logic signed [VALUE_W-1:0] o_value_res,
    output logic                      o_last_res,
    output logic                      o_overflow
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       emit;

    bis_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_last),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_emit   (emit)
    );

    bis_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_value  (i_value),
        .o_status (status),
        .o_head   (o_value_res)
    );

    assign o_res_valid = emit;
    assign o_last_res  = emit && status.one_left;
    assign o_overflow  = emit && status.dropped;

endmodule

// File: rtl/bis_checker.sv
// Port-level checker for the batch insertion sorter, bound to the top level.
// Depends on batch_insertion_sorter_unit_defines.svh for the assertion macros.
`include "batch_insertion_sorter_unit_defines.svh"

module bis_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_last,
    input logic        o_res_valid,
    input logic        o_last_res,
    input logic        o_overflow
);

    // A batch end starts the emission on the following cycle.
    `BIS_ASSERT(a_last_starts_emit, start && !busy && i_last |=> o_res_valid,
                "no result after batch end")

    // A word that does not end a batch produces nothing.
    `BIS_ASSERT(a_quiet_collect, start && !busy && !i_last |=> !o_res_valid,
                "result without batch end")

    // The final word closes the emission.
    `BIS_ASSERT(a_last_closes, o_res_valid && o_last_res |=> !o_res_valid,
                "result after final word")

    // Within a batch the words are contiguous and share one overflow flag.
    `BIS_ASSERT(a_batch_contig,
                o_res_valid && !o_last_res |=> o_res_valid && $stable(o_overflow),
                "gap or overflow change in batch")

    // Results only appear while new words are held off.
    `BIS_ASSERT_ALWAYS(a_valid_busy, o_res_valid |-> busy, "result while accepting")

endmodule

bind batch_insertion_sorter_unit bis_checker u_bis_checker (.*);

// File: sim/tb.sv
// Testbench for batch_insertion_sorter_unit: directed and random batches of signed
// words are sorted by a scoreboard of its own and the emitted words are checked in order.
// Depends on bis_pkg and the batch_insertion_sorter_unit RTL.
module tb
    import bis_pkg::*;
();

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam int STALL_LIMIT = 500;
    localparam int RANDOM_ITEMS = 215;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      overflow;
    } t_sorted_word;

    class sort_scoreboard;
        logic signed [VALUE_W-1:0] held[$];
        bit                        dropped;
        t_sorted_word              pending_words[$];
        int                        errors;
        int                        capacity = DEPTH_DEF;

        function int pending();
            return pending_words.size();
        endfunction

        // Mirrors the cell row: an equal word lands after those already held.
        function void note_input(logic signed [VALUE_W-1:0] v, logic l);
            int pos;
            t_sorted_word w;
            if (held.size() < capacity) begin
                pos = held.size();
                while (pos > 0 && held[pos-1] > v)
                    pos--;
                held.insert(pos, v);
            end else begin
                dropped = 1'b1;
            end
            if (l) begin
                foreach (held[k]) begin
                    w.value    = held[k];
                    w.last     = (k == held.size() - 1);
                    w.overflow = dropped;
                    pending_words.push_back(w);
                end
                held.delete();
                dropped = 1'b0;
            end
        endfunction

        function void check_result(logic signed [VALUE_W-1:0] v, logic l, logic ovf);
            t_sorted_word w;
            if (pending_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: value %0d last %0b overflow %0b",
                             v, l, ovf);
                return;
            end
            w = pending_words.pop_front();
            if (v !== w.value || l !== w.last || ovf !== w.overflow) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                             w.value, w.last, w.overflow, v, l, ovf);
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [VALUE_W-1:0] i_value;
    logic                      i_last;
    logic                      o_res_valid;
    logic signed [VALUE_W-1:0] o_value_res;
    logic                      o_last_res;
    logic                      o_overflow;

    sort_scoreboard sb;
    bit             idle_enabled;
    int             quiet_cycles;
    int             random_sent;

    batch_insertion_sorter_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_res_valid (o_res_valid),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res),
        .o_overflow  (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial sb = new;

    // Monitor and watchdog: words move only at rising edges.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            sb.note_input(i_value, i_last);
            quiet_cycles <= 0;
        end else if (i_rst_n && o_res_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (i_rst_n && o_res_valid)
            sb.check_result(o_value_res, o_last_res, o_overflow);
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic logic signed [VALUE_W-1:0] random_value();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6, 7:       return $signed($urandom_range(8)) - 4;
            8:             return $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
            default:       return $urandom_range(1) ? 32'sd0 : -32'sd1;
        endcase
    endfunction

    // Holds the word on the ports until the block takes it.
    task automatic put_word(input logic signed [VALUE_W-1:0] v, input logic l);
        start   <= 1'b1;
        i_value <= v;
        i_last  <= l;
        do @(posedge i_clk); while (busy);
    endtask

    // Lets the sender go idle before about a fifth of the words.
    task automatic maybe_idle();
        if (idle_enabled && $urandom_range(99) < 19) begin
            start   <= 1'b0;
            i_value <= $urandom;
            i_last  <= $urandom_range(1);
            @(posedge i_clk);
        end
    endtask

    // Stops sending until every expected word of the closed batches has come back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_batch(input int len);
        for (int k = 0; k < len; k++) begin
            maybe_idle();
            put_word(random_value(), k == len - 1);
            random_sent++;
            // The long stretch with no idle gaps runs through the middle of the words sent.
            idle_enabled = !(random_sent > 60 && random_sent < 130);
        end
    endtask

    initial begin
        int len;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_value <= '0;
        i_last  <= 1'b0;
        idle_enabled = 1'b1;
        random_sent  = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed batches: single word, extremes, equal keys, bit patterns.
        put_word(VALUE_MAX, 1'b1);
        put_word(VALUE_MIN, 1'b0);
        put_word(VALUE_MAX, 1'b0);
        put_word(32'sd0, 1'b0);
        put_word(-32'sd1, 1'b0);
        put_word(32'sd1, 1'b1);
        maybe_idle();
        put_word(32'sd7, 1'b0);
        put_word(-32'sd7, 1'b0);
        put_word(32'sd7, 1'b0);
        put_word(32'sd7, 1'b1);
        put_word(VALUE_MIN, 1'b0);
        put_word(VALUE_MIN, 1'b1);
        put_word(32'sh5555_5555, 1'b0);
        put_word(32'shAAAA_AAAA, 1'b0);
        put_word(32'sh7FFF_FFFE, 1'b1);
        drain();

        // A batch that exactly fills the row, then one that overflows it.
        run_batch(DEPTH_DEF);
        run_batch(DEPTH_DEF + 2);
        drain();
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       len = $urandom_range(11, DEPTH_DEF - 1);
                1:       len = $urandom_range(DEPTH_DEF, DEPTH_DEF + 4);
                default: len = $urandom_range(1, 10);
            endcase
            run_batch(len);
            if ($urandom_range(9) == 0)
                drain();
        end
        drain();
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
